### src/jsts_pkg.sv
// ----------------------------------------------------------------------------
// jsts_pkg
// Shared types and constants of the JSON-style token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package jsts_pkg;

    localparam int LINE_BITS   = 20;
    localparam int COL_BITS    = 16;
    localparam int LEN_BITS    = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]  LEN_MAX  = {LEN_BITS{1'b1}};

    // input word opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // characters with a role of their own
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CTRL   = 8'h20;
    localparam logic [7:0] CH_ASCII  = 8'h7F;
    localparam logic [15:0] CODE_LIMIT = 16'd128;

    typedef enum logic [4:0] {
        SM_IDLE    = 5'd0,
        SM_MINUS   = 5'd1,
        SM_SLASH   = 5'd2,
        SM_COMMENT = 5'd3,
        SM_IDENT   = 5'd4,
        SM_ZERO    = 5'd5,
        SM_BADZERO = 5'd6,
        SM_INT     = 5'd7,
        SM_DOT     = 5'd8,
        SM_FRAC    = 5'd9,
        SM_EXPMARK = 5'd10,
        SM_EXPSIGN = 5'd11,
        SM_EXP     = 5'd12,
        SM_STR     = 5'd13,
        SM_ESC     = 5'd14,
        SM_HEX     = 5'd15
    } scan_mode_t;

    typedef enum logic [2:0] {
        CLS_IDENT = 3'd0,
        CLS_NUM   = 3'd1,
        CLS_STR   = 3'd2,
        CLS_OTHER = 3'd3,
        CLS_BAD   = 3'd4,
        CLS_END   = 3'd5
    } tok_class_t;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  token_class;
        logic [19:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic [7:0]  first_byte;
        logic        last_of_run;
    } out_item_t;

    // one queue entry: the tokens caused by one source word
    typedef struct packed {
        logic      two;
        out_item_t tok0;
        out_item_t tok1;
    } tok_pair_t;

    typedef struct packed {
        logic not_empty;
        logic two;
    } queue_status_t;

endpackage

`default_nettype wire

### src/jsts_front.sv
// ----------------------------------------------------------------------------
// jsts_front
// Scanner front end: takes one source word a cycle while the queue has room,
// runs the lexer state and pushes the tokens that word closes as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module jsts_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire jsts_pkg::in_item_t src,
    input  wire logic               full,
    output logic                    push,
    output jsts_pkg::tok_pair_t     push_data
);

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0D, 8'h0A};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c inside {[8'h30:8'h39]})
            v = 4'(c - 8'h30);
        else if (c inside {[8'h41:8'h46]})
            v = 4'(c - 8'h37);
        else
            v = 4'(c - 8'h57);
        return v;
    endfunction

    jsts_pkg::scan_mode_t                mode_reg, mode_next;
    logic [jsts_pkg::LINE_BITS-1:0]      cur_line_reg, cur_line_next;
    logic [jsts_pkg::COL_BITS-1:0]       cur_col_reg, cur_col_next;
    logic [jsts_pkg::LINE_BITS-1:0]      tok_line_reg, tok_line_next;
    logic [jsts_pkg::COL_BITS-1:0]       tok_col_reg, tok_col_next;
    logic [jsts_pkg::LEN_BITS-1:0]       tok_len_reg, tok_len_next;
    logic [7:0]                          tok_first_reg, tok_first_next;
    logic                                failed_reg, failed_next;
    logic [2:0]                          hex_cnt_reg, hex_cnt_next;
    logic [15:0]                         code_acc_reg, code_acc_next;

    logic                        accept;
    logic [7:0]                  c;
    logic [jsts_pkg::LEN_BITS-1:0] len_inc;
    logic [15:0]                 acc_shift;
    logic                        p1_emit, fl_emit;
    jsts_pkg::tok_class_t        p1_cls, fl_cls;
    logic                        hex_abort, str_step, str_close, st, other_start;
    logic                        mode_busy;

    assign src_stall = full;
    assign accept    = src_valid && !full;
    assign c         = src.ch;
    assign len_inc   = (tok_len_reg == jsts_pkg::LEN_MAX) ? tok_len_reg
                                                          : tok_len_reg + 1'b1;
    assign acc_shift = {code_acc_reg[11:0], hex_val(c)};

    // decode: what the pending token does with this byte
    always_comb
    begin
        p1_emit = 1'b0;
        p1_cls  = jsts_pkg::CLS_OTHER;
        fl_emit = 1'b1;
        fl_cls  = jsts_pkg::CLS_BAD;
        mode_busy = 1'b1;
        case (mode_reg)
            jsts_pkg::SM_MINUS:
            begin
                p1_emit = !is_digit(c);
                fl_cls  = jsts_pkg::CLS_OTHER;
            end
            jsts_pkg::SM_SLASH:
            begin
                p1_emit = (c != jsts_pkg::CH_SLASH);
                fl_cls  = jsts_pkg::CLS_OTHER;
            end
            jsts_pkg::SM_COMMENT:
            begin
                fl_emit = 1'b0;
            end
            jsts_pkg::SM_IDENT:
            begin
                p1_emit = !(is_alpha(c) || is_digit(c));
                p1_cls  = jsts_pkg::CLS_IDENT;
                fl_cls  = jsts_pkg::CLS_IDENT;
            end
            jsts_pkg::SM_ZERO, jsts_pkg::SM_INT:
            begin
                p1_emit = !(is_digit(c) || c == jsts_pkg::CH_DOT || c == 8'h65 || c == 8'h45);
                p1_cls  = jsts_pkg::CLS_NUM;
                fl_cls  = jsts_pkg::CLS_NUM;
            end
            jsts_pkg::SM_FRAC:
            begin
                p1_emit = !(is_digit(c) || c == 8'h65 || c == 8'h45);
                p1_cls  = jsts_pkg::CLS_NUM;
                fl_cls  = jsts_pkg::CLS_NUM;
            end
            jsts_pkg::SM_EXP:
            begin
                p1_emit = !is_digit(c);
                p1_cls  = jsts_pkg::CLS_NUM;
                fl_cls  = jsts_pkg::CLS_NUM;
            end
            jsts_pkg::SM_BADZERO, jsts_pkg::SM_DOT, jsts_pkg::SM_EXPSIGN:
            begin
                p1_emit = !is_digit(c);
                p1_cls  = jsts_pkg::CLS_BAD;
            end
            jsts_pkg::SM_EXPMARK:
            begin
                p1_emit = !(is_digit(c) || c == jsts_pkg::CH_PLUS || c == jsts_pkg::CH_MINUS);
                p1_cls  = jsts_pkg::CLS_BAD;
            end
            jsts_pkg::SM_STR, jsts_pkg::SM_ESC, jsts_pkg::SM_HEX:
            begin
                p1_emit = 1'b0;
            end
            default:
            begin
                fl_emit   = 1'b0;
                mode_busy = 1'b0;
            end
        endcase
    end

    assign hex_abort   = (mode_reg == jsts_pkg::SM_HEX) && !is_hex(c);
    assign str_step    = (mode_reg == jsts_pkg::SM_STR) || hex_abort;
    assign str_close   = str_step && (c == jsts_pkg::CH_QUOTE);
    assign st          = p1_emit || !mode_busy;
    assign other_start = st && !is_space(c) && !is_alpha(c) && !is_digit(c)
                         && c != jsts_pkg::CH_SLASH && c != jsts_pkg::CH_MINUS
                         && c != jsts_pkg::CH_QUOTE;

    // outputs: tokens handed to the queue
    always_comb
    begin
        jsts_pkg::out_item_t tok_a, tok_s, tok_o, tok_f, tok_e;
        tok_a = '{token_class: p1_cls, start_line: tok_line_reg, start_column: tok_col_reg,
                  token_length: tok_len_reg, first_byte: tok_first_reg, last_of_run: 1'b0};
        tok_s = '{token_class: (failed_reg || hex_abort) ? jsts_pkg::CLS_BAD
                                                          : jsts_pkg::CLS_STR,
                  start_line: tok_line_reg, start_column: tok_col_reg,
                  token_length: len_inc, first_byte: tok_first_reg, last_of_run: 1'b0};
        tok_o = '{token_class: jsts_pkg::CLS_OTHER, start_line: cur_line_reg,
                  start_column: cur_col_reg, token_length: 16'd1, first_byte: c,
                  last_of_run: 1'b0};
        tok_f = '{token_class: fl_cls, start_line: tok_line_reg, start_column: tok_col_reg,
                  token_length: tok_len_reg, first_byte: tok_first_reg, last_of_run: 1'b0};
        tok_e = '{token_class: jsts_pkg::CLS_END, start_line: cur_line_reg,
                  start_column: cur_col_reg, token_length: 16'd0, first_byte: 8'd0,
                  last_of_run: 1'b0};
        push_data = '0;
        push      = 1'b0;
        if (src.op == jsts_pkg::OP_END)
        begin
            push = accept;
            if (fl_emit)
            begin
                push_data.two  = 1'b1;
                push_data.tok0 = tok_f;
                push_data.tok1 = tok_e;
            end
            else
            begin
                push_data.tok0 = tok_e;
            end
        end
        else
        begin
            push = accept && (p1_emit || str_close || other_start);
            push_data.two = p1_emit && other_start;
            if (p1_emit)
                push_data.tok0 = tok_a;
            else if (str_close)
                push_data.tok0 = tok_s;
            else
                push_data.tok0 = tok_o;
            push_data.tok1 = tok_o;
        end
        push_data.tok0.last_of_run = !push_data.two;
        push_data.tok1.last_of_run = 1'b1;
    end

    // next state
    always_comb
    begin
        mode_next      = mode_reg;
        cur_line_next  = cur_line_reg;
        cur_col_next   = cur_col_reg;
        tok_line_next  = tok_line_reg;
        tok_col_next   = tok_col_reg;
        tok_len_next   = tok_len_reg;
        tok_first_next = tok_first_reg;
        failed_next    = failed_reg;
        hex_cnt_next   = hex_cnt_reg;
        code_acc_next  = code_acc_reg;
        if (src.op == jsts_pkg::OP_END)
        begin
            mode_next      = jsts_pkg::SM_IDLE;
            cur_line_next  = jsts_pkg::LINE_BITS'(1);
            cur_col_next   = jsts_pkg::COL_BITS'(1);
            tok_line_next  = jsts_pkg::LINE_BITS'(1);
            tok_col_next   = jsts_pkg::COL_BITS'(1);
            tok_len_next   = '0;
            tok_first_next = '0;
            failed_next    = 1'b0;
            hex_cnt_next   = '0;
            code_acc_next  = '0;
        end
        else
        begin
            if (p1_emit)
                mode_next = jsts_pkg::SM_IDLE;
            else
            begin
                case (mode_reg)
                    jsts_pkg::SM_MINUS:
                    begin
                        tok_len_next = len_inc;
                        mode_next    = (c == jsts_pkg::CH_ZERO) ? jsts_pkg::SM_ZERO
                                                                : jsts_pkg::SM_INT;
                    end
                    jsts_pkg::SM_SLASH:
                        mode_next = jsts_pkg::SM_COMMENT;
                    jsts_pkg::SM_COMMENT:
                        if (c == jsts_pkg::CH_LF)
                            mode_next = jsts_pkg::SM_IDLE;
                    jsts_pkg::SM_IDENT, jsts_pkg::SM_BADZERO, jsts_pkg::SM_EXP:
                        tok_len_next = len_inc;
                    jsts_pkg::SM_ZERO, jsts_pkg::SM_INT, jsts_pkg::SM_FRAC:
                    begin
                        tok_len_next = len_inc;
                        if (is_digit(c))
                        begin
                            if (mode_reg == jsts_pkg::SM_ZERO)
                                mode_next = jsts_pkg::SM_BADZERO;
                        end
                        else if (c == jsts_pkg::CH_DOT)
                            mode_next = jsts_pkg::SM_DOT;
                        else
                            mode_next = jsts_pkg::SM_EXPMARK;
                    end
                    jsts_pkg::SM_DOT:
                    begin
                        tok_len_next = len_inc;
                        mode_next    = jsts_pkg::SM_FRAC;
                    end
                    jsts_pkg::SM_EXPMARK:
                    begin
                        tok_len_next = len_inc;
                        mode_next    = is_digit(c) ? jsts_pkg::SM_EXP : jsts_pkg::SM_EXPSIGN;
                    end
                    jsts_pkg::SM_EXPSIGN:
                    begin
                        tok_len_next = len_inc;
                        mode_next    = jsts_pkg::SM_EXP;
                    end
                    jsts_pkg::SM_ESC:
                    begin
                        tok_len_next = len_inc;
                        if (c == 8'h75)
                        begin
                            hex_cnt_next  = '0;
                            code_acc_next = '0;
                            mode_next     = jsts_pkg::SM_HEX;
                        end
                        else
                        begin
                            if (!(c inside {jsts_pkg::CH_QUOTE, jsts_pkg::CH_BSLASH, 8'h62,
                                            8'h66, 8'h6E, 8'h72, 8'h74}))
                                failed_next = 1'b1;
                            mode_next = jsts_pkg::SM_STR;
                        end
                    end
                    jsts_pkg::SM_HEX:
                    begin
                        if (!hex_abort)
                        begin
                            tok_len_next  = len_inc;
                            code_acc_next = acc_shift;
                            hex_cnt_next  = hex_cnt_reg + 1'b1;
                            if (hex_cnt_reg == 3'd3)
                            begin
                                if (acc_shift >= jsts_pkg::CODE_LIMIT)
                                    failed_next = 1'b1;
                                mode_next = jsts_pkg::SM_STR;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // string content, also for the byte that cut a \u escape short
            if (str_step)
            begin
                tok_len_next = len_inc;
                mode_next    = jsts_pkg::SM_STR;
                if (hex_abort)
                    failed_next = 1'b1;
                if (c < jsts_pkg::CH_CTRL || c > jsts_pkg::CH_ASCII)
                    failed_next = 1'b1;
                else if (c == jsts_pkg::CH_QUOTE)
                    mode_next = jsts_pkg::SM_IDLE;
                else if (c == jsts_pkg::CH_BSLASH)
                    mode_next = jsts_pkg::SM_ESC;
            end

            // open a new token
            if (st)
            begin
                mode_next = jsts_pkg::SM_IDLE;
                if (!is_space(c))
                begin
                    tok_line_next  = cur_line_reg;
                    tok_col_next   = cur_col_reg;
                    tok_first_next = c;
                    tok_len_next   = jsts_pkg::LEN_BITS'(1);
                    if (c == jsts_pkg::CH_SLASH)
                        mode_next = jsts_pkg::SM_SLASH;
                    else if (c == jsts_pkg::CH_MINUS)
                        mode_next = jsts_pkg::SM_MINUS;
                    else if (is_alpha(c))
                        mode_next = jsts_pkg::SM_IDENT;
                    else if (c == jsts_pkg::CH_ZERO)
                        mode_next = jsts_pkg::SM_ZERO;
                    else if (is_digit(c))
                        mode_next = jsts_pkg::SM_INT;
                    else if (c == jsts_pkg::CH_QUOTE)
                    begin
                        mode_next   = jsts_pkg::SM_STR;
                        failed_next = 1'b0;
                    end
                end
            end

            if (c == jsts_pkg::CH_LF)
            begin
                if (cur_line_reg != jsts_pkg::LINE_MAX)
                    cur_line_next = cur_line_reg + 1'b1;
                cur_col_next = jsts_pkg::COL_BITS'(1);
            end
            else if (cur_col_reg != jsts_pkg::COL_MAX)
                cur_col_next = cur_col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= jsts_pkg::SM_IDLE;
            cur_line_reg  <= jsts_pkg::LINE_BITS'(1);
            cur_col_reg   <= jsts_pkg::COL_BITS'(1);
            tok_line_reg  <= jsts_pkg::LINE_BITS'(1);
            tok_col_reg   <= jsts_pkg::COL_BITS'(1);
            tok_len_reg   <= '0;
            tok_first_reg <= '0;
            failed_reg    <= 1'b0;
            hex_cnt_reg   <= '0;
            code_acc_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            cur_line_reg  <= cur_line_next;
            cur_col_reg   <= cur_col_next;
            tok_line_reg  <= tok_line_next;
            tok_col_reg   <= tok_col_next;
            tok_len_reg   <= tok_len_next;
            tok_first_reg <= tok_first_next;
            failed_reg    <= failed_next;
            hex_cnt_reg   <= hex_cnt_next;
            code_acc_reg  <= code_acc_next;
        end
    end

    // end of input leaves the scanner as after reset
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && src.op == jsts_pkg::OP_END |=>
            mode_reg == jsts_pkg::SM_IDLE && cur_line_reg == jsts_pkg::LINE_BITS'(1))
        else $error("scanner state not cleared after end of input");

    // an end word always yields a queue entry ending in the end token
    a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && src.op == jsts_pkg::OP_END |->
            push && (push_data.two ? push_data.tok1.token_class
                                   : push_data.tok0.token_class) == jsts_pkg::CLS_END)
        else $error("end of input gave no end token");

endmodule

`default_nettype wire

### src/jsts_queue.sv
// ----------------------------------------------------------------------------
// jsts_queue
// Short queue of token pairs between scanner front end and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jsts_queue
#(
    parameter int DEPTH = jsts_pkg::QUEUE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire jsts_pkg::tok_pair_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output jsts_pkg::tok_pair_t      head,
    output jsts_pkg::queue_status_t  status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsts_pkg::tok_pair_t slots_reg [DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;

    assign full             = (count_reg == CW'(DEPTH));
    assign head             = slots_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.two       = head.two;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("token queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.not_empty)
        else $error("token queue read while empty");

endmodule

`default_nettype wire

### src/jsts_back.sv
// ----------------------------------------------------------------------------
// jsts_back
// Output stage: splits queued token pairs into single words and holds the
// result word while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module jsts_back
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire jsts_pkg::tok_pair_t     head,
    input  wire jsts_pkg::queue_status_t status,
    output logic                         pop,
    output logic                         tok_valid,
    input  wire logic                    tok_stall,
    output jsts_pkg::out_item_t          tok
);

    logic                valid_reg, valid_next;
    logic                sel_reg, sel_next;
    jsts_pkg::out_item_t data_reg, data_next;
    logic                load;

    assign load      = !valid_reg || !tok_stall;
    assign pop       = load && status.not_empty && (sel_reg || !status.two);
    assign tok_valid = valid_reg;
    assign tok       = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = status.not_empty;
            if (status.not_empty)
            begin
                data_next = sel_reg ? head.tok1 : head.tok0;
                // advance to the second token, or drop the entry
                sel_next  = !sel_reg && status.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    a_sel_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> status.not_empty && status.two)
        else $error("second token selected without a pair at the head");

    a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !tok_stall && !data_reg.last_of_run |=> valid_reg)
        else $error("run broken before its last word");

endmodule

`default_nettype wire

### src/json_style_token_scanner_unit.sv
// ----------------------------------------------------------------------------
// json_style_token_scanner_unit
// Streaming lexer for JSON-style text: identifiers, numbers, strings, single
// characters, with line/column tracking and // comments skipped.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake            | word
//   --------+-----+----------------------+--------------------------------------
//   src     | in  | src_valid/src_stall  | in_item_t  {op, ch}
//   tok     | out | tok_valid/tok_stall  | out_item_t {class, line, col, len, ...}
//
// One source word is taken every cycle while the token queue has room.
// Tokens leave one word per cycle while tok_stall is low; a source word that closes
// two tokens gives two output words, and the queue absorbs such bursts.
// Reset is asynchronous; no clearing pass, the scanner is ready at once.
// src_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module json_style_token_scanner_unit
#(
    parameter int QUEUE_DEPTH = jsts_pkg::QUEUE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                src_valid,
    output logic                     src_stall,
    input  wire jsts_pkg::in_item_t  src,
    output logic                     tok_valid,
    input  wire logic                tok_stall,
    output jsts_pkg::out_item_t      tok
);

    logic                    q_full;
    logic                    q_push;
    logic                    q_pop;
    jsts_pkg::tok_pair_t     q_wdata;
    jsts_pkg::tok_pair_t     q_head;
    jsts_pkg::queue_status_t q_status;

    jsts_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src       (src),
        .full      (q_full),
        .push      (q_push),
        .push_data (q_wdata)
    );

    jsts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    jsts_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .status    (q_status),
        .pop       (q_pop),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok)
    );

endmodule

`default_nettype wire
